// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sequence counter.
// Depends on a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FTSC_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define FTSC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ftsc_pkg.sv
// Package of the forbidden-transition sequence counter.
// Holds field widths, the modulus, opcodes and the sequencer state type; no dependencies.
`default_nettype none

package ftsc_pkg;

   localparam int MAX_COLORS_DEF = 16;

   localparam int OPCODE_W = 1;
   localparam int COLOR_W  = 4;
   localparam int MASK_W   = 16;
   localparam int LEN_W    = 16;
   localparam int COUNT_W  = 30;
   localparam int CFG_W    = 5;

   localparam logic [COUNT_W-1:0] MODULUS = 30'd1000000007;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD    = 1'b0,
      OP_COMPUTE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FLUSH,
      ST_HOLD
   } state_type;

endpackage : ftsc_pkg

`default_nettype wire

// File: hw/rtl/ftsc_mod_add.sv
// Modular adder: sum of two residues with one conditional subtract of the modulus.
// Depends on ftsc_pkg.
`default_nettype none

module ftsc_mod_add (
   input  logic [ftsc_pkg::COUNT_W-1:0] addend_a,
   input  logic [ftsc_pkg::COUNT_W-1:0] addend_b,
   output logic [ftsc_pkg::COUNT_W-1:0] sum
);
   import ftsc_pkg::*;

   logic [COUNT_W:0] raw_sum;
   logic [COUNT_W:0] wrapped_sum;

   assign raw_sum     = {1'b0, addend_a} + {1'b0, addend_b};
   assign wrapped_sum = raw_sum - {1'b0, MODULUS};
   assign sum = (raw_sum >= {1'b0, MODULUS}) ? wrapped_sum[COUNT_W-1:0]
                                             : raw_sum[COUNT_W-1:0];

endmodule : ftsc_mod_add

`default_nettype wire

// File: hw/rtl/forbidden_transition_sequence_counter_core.sv
// Top level of the forbidden-transition sequence counter; uses ftsc_pkg, ftsc_mod_add, macros.
// A compute item with N colours and length L shows a zero result when N or L is zero;
// otherwise one shared modular adder takes one count-memory read per cycle, plus a drain
// state after each built position.
// One item at a time; loads are taken while a finished result waits at the output.
// Synchronous active-high reset: table cleared, colour count 1, idle, no result pending.
`default_nettype none
`include "assert_macros.svh"

module forbidden_transition_sequence_counter_core #(
   parameter int MAX_COLORS = ftsc_pkg::MAX_COLORS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_enable,
   input  logic [ftsc_pkg::CFG_W-1:0]    csr_write_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ftsc_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [ftsc_pkg::COLOR_W-1:0]  req_row_color,
   input  logic [ftsc_pkg::MASK_W-1:0]   req_forbidden_mask,
   input  logic [ftsc_pkg::LEN_W-1:0]    req_sequence_length,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ftsc_pkg::COUNT_W-1:0]  rsp_sequence_count
);
   import ftsc_pkg::*;

   // Colour index width, and a ping-pong count memory: one bank holds the
   // counts of the current position, the other collects the next position.
   localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int ADDR_W = IDX_W + 1;
   localparam int MEM_DEPTH = 2 ** ADDR_W;
   localparam logic [CFG_W-1:0] MAX_CFG = CFG_W'(MAX_COLORS);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]   color_count_ff, color_count_in;
   logic [MASK_W-1:0]  table_ff [MAX_COLORS];
   state_type          state_ff, state_in;

   // sequencer
   logic [IDX_W-1:0]   last_idx_ff, last_idx_in;   // colours in use, minus one
   logic [IDX_W-1:0]   j_ff, j_in;                 // colour being summed for
   logic [IDX_W-1:0]   k_ff, k_in;                 // predecessor being read
   logic               bank_ff, bank_in;           // bank holding current counts
   logic               ones_ff, ones_in;           // current counts are all ones
   logic               final_ff, final_in;         // closing pass sums everything
   logic [LEN_W-1:0]   pass_left_ff, pass_left_in; // positions still to build

   // accumulate stage, aligned with the registered memory read
   logic               p_valid_ff, p_valid_in;
   logic               p_first_ff, p_first_in;
   logic               p_last_ff, p_last_in;
   logic               p_allowed_ff, p_allowed_in;
   logic               p_ones_ff, p_ones_in;
   logic               p_final_ff, p_final_in;
   logic [IDX_W-1:0]   p_j_ff, p_j_in;
   logic               p_wbank_ff, p_wbank_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;

   logic [COUNT_W-1:0] result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // count memory
   logic [COUNT_W-1:0] count_mem [MEM_DEPTH];
   logic [COUNT_W-1:0] rdata_ff;

   // ---------------------------------------------------------------------
   // Combinational signals
   // ---------------------------------------------------------------------
   logic               req_accept;
   logic               load_write;
   logic [CFG_W-1:0]   color_sat;
   logic [CFG_W-1:0]   color_last;
   logic               compute_empty;
   logic               issue;
   logic               k_last;
   logic               j_last;
   logic [MASK_W-1:0]  row_bits;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0]  mem_waddr;
   logic               mem_we;
   logic [COUNT_W-1:0] operand_a;
   logic [COUNT_W-1:0] operand_b;
   logic [COUNT_W-1:0] stage_sum;
   logic               result_ready;
   logic               out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // A load beyond the built table is dropped.
   assign load_write = req_accept && (req_opcode == OP_LOAD)
                       && ({1'b0, req_row_color} < MAX_CFG);

   // Saturate the colour count to the built maximum.
   assign color_sat     = (color_count_ff > MAX_CFG) ? MAX_CFG : color_count_ff;
   assign color_last    = color_sat - CFG_W'(1);
   assign compute_empty = (color_sat == '0) || (req_sequence_length == '0);

   assign issue    = (state_ff == ST_RUN);
   assign k_last   = (k_ff == last_idx_ff);
   assign j_last   = (j_ff == last_idx_ff);
   assign row_bits = table_ff[j_ff];

   assign mem_raddr = {bank_ff, k_ff};
   assign mem_waddr = {p_wbank_ff, p_j_ff};
   assign mem_we    = p_valid_ff && p_last_ff && !p_final_ff;

   // Accumulate: restart on the first predecessor, skip forbidden ones, and
   // read a count of one on the first position instead of the memory.
   assign operand_a = p_first_ff ? '0 : acc_ff;
   assign operand_b = !p_allowed_ff ? '0 : (p_ones_ff ? COUNT_W'(1) : rdata_ff);

   ftsc_mod_add u_mod_add (
      .addend_a (operand_a),
      .addend_b (operand_b),
      .sum      (stage_sum)
   );

   assign result_ready = p_valid_ff && p_last_ff && p_final_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      last_idx_in  = last_idx_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      bank_in      = bank_ff;
      ones_in      = ones_ff;
      final_in     = final_ff;
      pass_left_in = pass_left_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;

      color_count_in = csr_write_enable ? csr_write_data : color_count_ff;

      // Issue one predecessor read per cycle while running.
      p_valid_in   = issue;
      p_first_in   = (k_ff == '0);
      p_last_in    = k_last;
      p_allowed_in = final_ff || !row_bits[k_ff];
      p_ones_in    = ones_ff;
      p_final_in   = final_ff;
      p_j_in       = j_ff;
      p_wbank_in   = !bank_ff;
      acc_in       = p_valid_ff ? stage_sum : acc_ff;

      if (result_ready) begin
         result_in = stage_sum;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_opcode == OP_COMPUTE)) begin
               last_idx_in  = color_last[IDX_W-1:0];
               j_in         = '0;
               k_in         = '0;
               bank_in      = 1'b0;
               ones_in      = 1'b1;
               pass_left_in = req_sequence_length - LEN_W'(1);
               final_in     = (req_sequence_length == LEN_W'(1));
               if (compute_empty) begin
                  result_in = '0;
                  state_in  = ST_HOLD;
               end else begin
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (k_last) begin
               k_in = '0;
               if (final_ff) begin
                  state_in = ST_FLUSH;
               end else if (j_last) begin
                  // Position complete: swap banks and let the last write land.
                  j_in         = '0;
                  bank_in      = !bank_ff;
                  ones_in      = 1'b0;
                  pass_left_in = pass_left_ff - LEN_W'(1);
                  final_in     = (pass_left_ff == LEN_W'(1));
                  state_in     = ST_DRAIN;
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_RUN;
         end
         ST_FLUSH: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            // Hand the count over once the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         color_count_ff <= CFG_W'(1);
         p_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_COLORS; i++) begin
            table_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         color_count_ff <= color_count_in;
         p_valid_ff     <= p_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (load_write) begin
            table_ff[req_row_color[IDX_W-1:0]] <= req_forbidden_mask;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      last_idx_ff  <= last_idx_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      bank_ff      <= bank_in;
      ones_ff      <= ones_in;
      final_ff     <= final_in;
      pass_left_ff <= pass_left_in;
      p_first_ff   <= p_first_in;
      p_last_ff    <= p_last_in;
      p_allowed_ff <= p_allowed_in;
      p_ones_ff    <= p_ones_in;
      p_final_ff   <= p_final_in;
      p_j_ff       <= p_j_in;
      p_wbank_ff   <= p_wbank_in;
      acc_ff       <= acc_in;
      result_ff    <= result_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Count memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= stage_sum;
      end
      rdata_ff <= count_mem[mem_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_count = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `FTSC_ASSERT_IMPL(a_no_same_entry, mem_we && issue, mem_waddr != mem_raddr, "entry clash")
   `FTSC_ASSERT_IMPL(a_result_in_flush, result_ready, state_ff == ST_FLUSH, "sum outside flush")
   `FTSC_ASSERT_IMPL(a_k_range, issue, k_ff <= last_idx_ff, "predecessor beyond colours in use")
   `FTSC_ASSERT_IMPL(a_j_range, issue, j_ff <= last_idx_ff, "colour beyond colours in use")
   `FTSC_ASSERT(a_rsp_below_modulus, !rsp_valid_ff || (rsp_count_ff < MODULUS), "count unreduced")

endmodule : forbidden_transition_sequence_counter_core

`default_nettype wire
